FILE: sv/sspg_pkg.sv
`default_nettype none
package sspg_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int COORD_BITS     = 16;
  localparam int CFG_W          = 48;
  localparam int IDX_W          = 3;
  localparam int CRD_W          = 34;   // CORDIC x/y, Q2.30 plus headroom
  localparam int CRZ_W          = 33;   // CORDIC residual angle
  localparam int PNT_W          = 36;   // point coordinates, 15 fraction bits
  localparam int PRD_W          = 52;   // coordinate times Q1.15
  localparam int ACC_W          = 54;
  localparam int STEP_W         = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = 5'd24;
  localparam logic [3:0]        ITER_LAST = 4'd15;

  typedef enum logic [IDX_W-1:0] {
    REG_THETA_RATE  = 3'd0,
    REG_PHI_RATE    = 3'd1,
    REG_RADIUS      = 3'd2,
    REG_START_TILTS = 3'd3,
    REG_TILT_STEPS  = 3'd4,
    REG_THRESHOLD   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ANG_TH, ANG_PH, ANG_TX, ANG_TY, ANG_TZ
  } ang_sel_t;

  typedef enum logic [2:0] {
    A_R, A_ACC, A_X, A_Y, A_Z, A_YX, A_ZX, A_XY
  } a_sel_t;

  typedef enum logic [3:0] {
    B_CT, B_ST, B_CP, B_SP, B_CX, B_SX, B_CY, B_SY, B_CZ, B_SZ
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_t;

  typedef enum logic [3:0] {
    D_NONE, D_X, D_Y, D_Z, D_YX, D_ZX, D_XY, D_ZY, D_XZ, D_YZ
  } dest_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PH_TH, ST_PH_PH, ST_COR_INIT, ST_COR_ITER, ST_COR_STORE, ST_MATH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic    mul_en;
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    dest_t   dest;
  } uop_t;

  typedef struct packed {
    logic     load_t;
    logic     ph_en;
    logic     ph_sel;     // 0: theta, 1: phi
    logic     cor_init;
    logic     cor_iter;
    logic     cor_store;
    logic [3:0] iter;
    ang_sel_t ang;
    uop_t     uop;
    logic     finish;
  } cmd_t;

  function automatic logic signed [CRZ_W-1:0] atan_at(input logic [3:0] i);
    logic signed [CRZ_W-1:0] v;
    unique case (i)
      4'd0:  v = 33'sd536870912;
      4'd1:  v = 33'sd316933406;
      4'd2:  v = 33'sd167458908;
      4'd3:  v = 33'sd85004756;
      4'd4:  v = 33'sd42667331;
      4'd5:  v = 33'sd21354465;
      4'd6:  v = 33'sd10679838;
      4'd7:  v = 33'sd5340245;
      4'd8:  v = 33'sd2670163;
      4'd9:  v = 33'sd1335087;
      4'd10: v = 33'sd667544;
      4'd11: v = 33'sd333772;
      4'd12: v = 33'sd166886;
      4'd13: v = 33'sd83443;
      4'd14: v = 33'sd41722;
      4'd15: v = 33'sd20861;
    endcase
    return v;
  endfunction

  // Round a CORDIC output to Q1.15 and clamp to +-32767.
  function automatic logic signed [15:0] trig_sat(input logic signed [CRD_W-1:0] v,
                                                  input logic neg);
    logic signed [CRD_W:0] s;
    logic signed [CRD_W:0] r;
    logic signed [19:0]    q;
    logic signed [15:0]    o;
    s = neg ? -{v[CRD_W-1], v} : {v[CRD_W-1], v};
    r = s + 35'sd16384;
    q = r[CRD_W:15];
    if (q > 20'sd32767) o = 16'sd32767;
    else if (q < -20'sd32767) o = -16'sd32767;
    else o = q[15:0];
    return o;
  endfunction

  function automatic logic [15:0] out_sat(input logic signed [PNT_W-1:0] v);
    localparam int SAT_HI = (1 << (COORD_BITS - 1)) - 1;
    localparam int SAT_LO = -(1 << (COORD_BITS - 1));
    logic signed [PNT_W:0] w;
    logic signed [24:0]    s;
    w = {v[PNT_W-1], v} + 37'sd16384;
    s = 25'(w >>> 15);
    if (s > $signed(25'(SAT_HI))) s = $signed(25'(SAT_HI));
    else if (s < $signed(25'(SAT_LO))) s = $signed(25'(SAT_LO));
    return s[15:0];
  endfunction

  function automatic uop_t mk(input logic m, input a_sel_t a, input b_sel_t b,
                              input acc_op_t op, input dest_t d);
    uop_t u;
    u.mul_en = m;
    u.a_sel  = a;
    u.b_sel  = b;
    u.acc_op = op;
    u.dest   = d;
    return u;
  endfunction

  // Point math: each product is registered and reaches the accumulator on the next step.
  function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
    uop_t u;
    unique case (step)
      5'd0:  u = mk(1'b1, A_R,   B_CT, ACC_NONE, D_NONE);
      5'd1:  u = mk(1'b0, A_R,   B_CT, ACC_LOAD, D_NONE);
      5'd2:  u = mk(1'b1, A_ACC, B_SP, ACC_NONE, D_NONE);
      5'd3:  u = mk(1'b0, A_R,   B_CT, ACC_LOAD, D_NONE);
      5'd4:  u = mk(1'b1, A_R,   B_ST, ACC_NONE, D_X);
      5'd5:  u = mk(1'b0, A_R,   B_CT, ACC_LOAD, D_NONE);
      5'd6:  u = mk(1'b1, A_ACC, B_SP, ACC_NONE, D_NONE);
      5'd7:  u = mk(1'b0, A_R,   B_CT, ACC_LOAD, D_NONE);
      5'd8:  u = mk(1'b1, A_R,   B_CP, ACC_NONE, D_Y);
      5'd9:  u = mk(1'b0, A_R,   B_CT, ACC_LOAD, D_NONE);
      5'd10: u = mk(1'b1, A_Y,   B_CX, ACC_NONE, D_Z);
      5'd11: u = mk(1'b1, A_Z,   B_SX, ACC_LOAD, D_NONE);
      5'd12: u = mk(1'b1, A_Y,   B_SX, ACC_SUB,  D_NONE);
      5'd13: u = mk(1'b1, A_Z,   B_CX, ACC_LOAD, D_YX);
      5'd14: u = mk(1'b1, A_X,   B_CY, ACC_ADD,  D_NONE);
      5'd15: u = mk(1'b0, A_R,   B_CT, ACC_LOAD, D_ZX);
      5'd16: u = mk(1'b1, A_ZX,  B_SY, ACC_NONE, D_NONE);
      5'd17: u = mk(1'b1, A_ZX,  B_CY, ACC_ADD,  D_NONE);
      5'd18: u = mk(1'b1, A_X,   B_SY, ACC_LOAD, D_XY);
      5'd19: u = mk(1'b1, A_XY,  B_CZ, ACC_SUB,  D_NONE);
      5'd20: u = mk(1'b1, A_YX,  B_SZ, ACC_LOAD, D_ZY);
      5'd21: u = mk(1'b1, A_XY,  B_SZ, ACC_SUB,  D_NONE);
      5'd22: u = mk(1'b1, A_YX,  B_CZ, ACC_LOAD, D_XZ);
      5'd23: u = mk(1'b0, A_R,   B_CT, ACC_ADD,  D_NONE);
      5'd24: u = mk(1'b0, A_R,   B_CT, ACC_NONE, D_YZ);
      default: u = mk(1'b0, A_R, B_CT, ACC_NONE, D_NONE);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

FILE: sv/sspg_ctrl.sv
`default_nettype none
module sspg_ctrl import sspg_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire  out_ready,
  output cmd_t cmd
);

  state_t            state_r, state_nxt;
  ang_sel_t          ang_r, ang_nxt;
  logic [3:0]        iter_r, iter_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ang_r       <= ANG_TH;
      iter_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ang_r       <= ang_nxt;
      iter_r      <= iter_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ang_nxt       = ang_r;
    iter_nxt      = iter_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.ang       = ang_r;
    cmd.iter      = iter_r;
    cmd.uop       = uop_rom(step_r);
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_t = 1'b1;
          state_nxt  = ST_PH_TH;
        end
      end
      ST_PH_TH: begin
        cmd.ph_en  = 1'b1;
        cmd.ph_sel = 1'b0;
        state_nxt  = ST_PH_PH;
      end
      ST_PH_PH: begin
        cmd.ph_en  = 1'b1;
        cmd.ph_sel = 1'b1;
        ang_nxt    = ANG_TH;
        state_nxt  = ST_COR_INIT;
      end
      ST_COR_INIT: begin
        cmd.cor_init = 1'b1;
        iter_nxt     = '0;
        state_nxt    = ST_COR_ITER;
      end
      ST_COR_ITER: begin
        cmd.cor_iter = 1'b1;
        iter_nxt     = iter_r + 4'd1;
        if (iter_r == ITER_LAST) state_nxt = ST_COR_STORE;
      end
      ST_COR_STORE: begin
        cmd.cor_store = 1'b1;
        state_nxt     = ST_COR_INIT;
        unique case (ang_r)
          ANG_TH: ang_nxt = ANG_PH;
          ANG_PH: ang_nxt = ANG_TX;
          ANG_TX: ang_nxt = ANG_TY;
          ANG_TY: ang_nxt = ANG_TZ;
          default: begin
            step_nxt  = '0;
            state_nxt = ST_MATH;
          end
        endcase
      end
      ST_MATH: begin
        step_nxt = step_r + 5'd1;
        if (step_r == STEP_LAST) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r != ST_MATH) cmd.uop = mk(1'b0, A_R, B_CT, ACC_NONE, D_NONE);
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: sv/sspg_datapath.sv
`default_nettype none
module sspg_datapath import sspg_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire  [IDX_W-1:0] cfg_index,
  input  wire  [CFG_W-1:0] cfg_data,
  input  wire  [31:0]      in_t,
  input  cmd_t             cmd,
  output logic [15:0]      out_x_out,
  output logic [15:0]      out_y_out,
  output logic [15:0]      out_z_out
);

  // configuration and tilt state
  logic [31:0] theta_rate_r, phi_rate_r, thresh_r;
  logic [14:0] radius_r;
  logic [47:0] tilt_steps_r;
  logic [15:0] tilt_x_r, tilt_y_r, tilt_z_r;

  logic [31:0] t_r;
  logic [ANGLE_BITS-1:0] th_q_r, ph_q_r;

  logic signed [CRD_W-1:0] cr_x_r, cr_y_r;
  logic signed [CRZ_W-1:0] cr_z_r;
  logic                    neg_r;

  logic signed [15:0] cos_th_r, sin_th_r, cos_ph_r, sin_ph_r;
  logic signed [15:0] cos_tx_r, sin_tx_r, cos_ty_r, sin_ty_r, cos_tz_r, sin_tz_r;

  logic signed [PNT_W-1:0] px_r, py_r, pz_r, yx_r, zx_r, xy_r, zy_r, xz_r, yz_r;
  logic signed [PRD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [15:0] out_x_r, out_y_r, out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_rate_r <= '0;
      phi_rate_r   <= '0;
      radius_r     <= '0;
      tilt_steps_r <= '0;
      thresh_r     <= '0;
      tilt_x_r     <= '0;
      tilt_y_r     <= '0;
      tilt_z_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THETA_RATE: theta_rate_r <= cfg_data[31:0];
        REG_PHI_RATE:   phi_rate_r   <= cfg_data[31:0];
        REG_RADIUS:     radius_r     <= cfg_data[14:0];
        REG_START_TILTS: begin
          tilt_x_r <= cfg_data[15:0];
          tilt_y_r <= cfg_data[31:16];
          tilt_z_r <= cfg_data[47:32];
        end
        REG_TILT_STEPS: tilt_steps_r <= cfg_data;
        REG_THRESHOLD:  thresh_r     <= cfg_data[31:0];
        default: ;
      endcase
    end else if (cmd.finish && (t_r > thresh_r)) begin
      tilt_x_r <= tilt_x_r + tilt_steps_r[15:0];
      tilt_y_r <= tilt_y_r + tilt_steps_r[31:16];
      tilt_z_r <= tilt_z_r + tilt_steps_r[47:32];
    end
  end

  // phase: low word of t times rate, top bits kept
  logic [31:0] ph_prod;
  assign ph_prod = t_r * (cmd.ph_sel ? phi_rate_r : theta_rate_r);

  always_ff @(posedge clk) begin
    if (cmd.load_t) t_r <= in_t;
    if (cmd.ph_en) begin
      if (cmd.ph_sel) ph_q_r <= ph_prod[31 -: ANGLE_BITS];
      else            th_q_r <= ph_prod[31 -: ANGLE_BITS];
    end
  end

  // CORDIC
  logic [31:0]             tilt_w;
  logic [ANGLE_BITS-1:0]   ang_q;
  logic [31:0]             p32, fold;
  logic                    fold_neg;
  logic signed [CRD_W-1:0] sh_x, sh_y;
  logic signed [CRZ_W-1:0] atan_v;
  logic signed [15:0]      cos_v, sin_v;

  always_comb begin
    unique case (cmd.ang)
      ANG_TX:  tilt_w = {tilt_x_r, 16'h0000};
      ANG_TY:  tilt_w = {tilt_y_r, 16'h0000};
      default: tilt_w = {tilt_z_r, 16'h0000};
    endcase
    unique case (cmd.ang)
      ANG_TH:  ang_q = th_q_r;
      ANG_PH:  ang_q = ph_q_r;
      default: ang_q = tilt_w[31 -: ANGLE_BITS];
    endcase
    p32      = {ang_q, {(32 - ANGLE_BITS){1'b0}}};
    fold     = p32 + 32'h4000_0000;
    fold_neg = fold[31];
    sh_x     = cr_x_r >>> cmd.iter;
    sh_y     = cr_y_r >>> cmd.iter;
    atan_v   = atan_at(cmd.iter);
    cos_v    = trig_sat(cr_x_r, neg_r);
    sin_v    = trig_sat(cr_y_r, neg_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.cor_init) begin
      cr_x_r <= 34'sd652032874;
      cr_y_r <= '0;
      // fold into a quarter turn either side of zero
      cr_z_r <= $signed({p32[31] ^ fold_neg, p32[31] ^ fold_neg, p32[30:0]});
      neg_r  <= fold_neg;
    end else if (cmd.cor_iter) begin
      if (!cr_z_r[CRZ_W-1]) begin
        cr_x_r <= cr_x_r - sh_y;
        cr_y_r <= cr_y_r + sh_x;
        cr_z_r <= cr_z_r - atan_v;
      end else begin
        cr_x_r <= cr_x_r + sh_y;
        cr_y_r <= cr_y_r - sh_x;
        cr_z_r <= cr_z_r + atan_v;
      end
    end
    if (cmd.cor_store) begin
      unique case (cmd.ang)
        ANG_TH: begin cos_th_r <= cos_v; sin_th_r <= sin_v; end
        ANG_PH: begin cos_ph_r <= cos_v; sin_ph_r <= sin_v; end
        ANG_TX: begin cos_tx_r <= cos_v; sin_tx_r <= sin_v; end
        ANG_TY: begin cos_ty_r <= cos_v; sin_ty_r <= sin_v; end
        default: begin cos_tz_r <= cos_v; sin_tz_r <= sin_v; end
      endcase
    end
  end

  // shared multiply-accumulate
  logic signed [PNT_W-1:0] mul_a;
  logic signed [15:0]      mul_b;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [PNT_W-1:0] wr_val;

  always_comb begin
    unique case (cmd.uop.a_sel)
      A_R:   mul_a = $signed({{(PNT_W - 15){1'b0}}, radius_r});
      A_ACC: mul_a = acc_r[PNT_W-1:0];
      A_X:   mul_a = px_r;
      A_Y:   mul_a = py_r;
      A_Z:   mul_a = pz_r;
      A_YX:  mul_a = yx_r;
      A_ZX:  mul_a = zx_r;
      A_XY:  mul_a = xy_r;
    endcase
    unique case (cmd.uop.b_sel)
      B_CT:    mul_b = cos_th_r;
      B_ST:    mul_b = sin_th_r;
      B_CP:    mul_b = cos_ph_r;
      B_SP:    mul_b = sin_ph_r;
      B_CX:    mul_b = cos_tx_r;
      B_SX:    mul_b = sin_tx_r;
      B_CY:    mul_b = cos_ty_r;
      B_SY:    mul_b = sin_ty_r;
      B_CZ:    mul_b = cos_tz_r;
      B_SZ:    mul_b = sin_tz_r;
      default: mul_b = '0;
    endcase
    acc_rnd = acc_r + 54'sd16384;
    // z keeps its full scale, every other point value drops 15 fraction bits
    wr_val  = (cmd.uop.dest == D_Z) ? acc_r[PNT_W-1:0] : acc_rnd[PNT_W+14:15];
  end

  always_ff @(posedge clk) begin
    if (cmd.uop.mul_en) prod_r <= mul_a * mul_b;
    unique case (cmd.uop.acc_op)
      ACC_LOAD: acc_r <= ACC_W'(prod_r);
      ACC_ADD:  acc_r <= acc_r + ACC_W'(prod_r);
      ACC_SUB:  acc_r <= acc_r - ACC_W'(prod_r);
      default:  ;
    endcase
    unique case (cmd.uop.dest)
      D_X:     px_r <= wr_val;
      D_Y:     py_r <= wr_val;
      D_Z:     pz_r <= wr_val;
      D_YX:    yx_r <= wr_val;
      D_ZX:    zx_r <= wr_val;
      D_XY:    xy_r <= wr_val;
      D_ZY:    zy_r <= wr_val;
      D_XZ:    xz_r <= wr_val;
      D_YZ:    yz_r <= wr_val;
      default: ;
    endcase
    if (cmd.finish) begin
      out_x_r <= out_sat(xz_r);
      out_y_r <= out_sat(yz_r);
      out_z_r <= out_sat(zy_r);
    end
  end

  assign out_x_out = out_x_r;
  assign out_y_out = out_y_r;
  assign out_z_out = out_z_r;

endmodule
`default_nettype wire

FILE: sv/spiral_sphere_point_generator_unit.sv
// After the input transfer come 2 phase multiplies, 5 angles through the CORDIC
// (init, iterations, store for each), 25 multiply-accumulate steps and 1 output load.
// A new input waits until the last has passed the single shared CORDIC and multiplier.
// A new input is taken while the previous result still waits in the output register.
// Reset (synchronous, rst_n low) clears the sequencer, configuration and tilt phases.
`default_nettype none
module spiral_sphere_point_generator_unit import sspg_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cfg_we,
  input  wire  [IDX_W-1:0] cfg_index,
  input  wire  [CFG_W-1:0] cfg_data,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [31:0]      in_t,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [15:0]      out_x_out,
  output logic [15:0]      out_y_out,
  output logic [15:0]      out_z_out
);

  cmd_t cmd;

  sspg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sspg_datapath #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_t      (in_t),
    .cmd       (cmd),
    .out_x_out (out_x_out),
    .out_y_out (out_y_out),
    .out_z_out (out_z_out)
  );

endmodule
`default_nettype wire
